>>> sv/lcdws_pkg.sv
// ---------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants for the character-LCD write sequencer: request
// codes, the byte transfer passed from the front end to the bus back end,
// and the queue sizing.
// ---------------------------------------------------------------------------
package lcdws_pkg;

  // Request operation codes.
  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_CMD     = 3'd1;
  localparam logic [2:0] OP_DATA    = 3'd2;
  localparam logic [2:0] OP_DATA_AT = 3'd3;
  localparam logic [2:0] OP_GLYPH   = 3'd4;

  // Register-select levels.
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Byte steps inside one request.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP    = 4'd8;
  localparam logic [STEP_W-1:0] GLYPH_FIRST_ROW   = 4'd1;
  localparam logic [STEP_W-1:0] GLYPH_LAST_ROW    = 4'd8;
  localparam logic [STEP_W-1:0] GLYPH_CURSOR_STEP = 4'd9;
  localparam logic [STEP_W-1:0] GLYPH_LAST_STEP   = 4'd10;

  // Byte queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One byte transfer on the LCD bus.
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } xfer_t;

  // Command bytes of the power-up sequence, in order.
  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step,
                                           input logic eight_lines);
    logic [7:0] b;
    case (step)
      4'd0, 4'd1, 4'd2: b = 8'h38;
      4'd3:             b = 8'h01;
      4'd4:             b = 8'h02;
      4'd5:             b = 8'h06;
      4'd6:             b = 8'h0C;
      4'd7:             b = eight_lines ? 8'h38 : 8'h28;
      default:          b = 8'h80;
    endcase
    return b;
  endfunction

  // DDRAM base address command of a display row 1 to 4.
  function automatic logic [7:0] row_base(input logic [2:0] row);
    logic [7:0] b;
    case (row)
      3'd1:    b = 8'h80;
      3'd2:    b = 8'hC0;
      3'd3:    b = 8'h90;
      3'd4:    b = 8'hD0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/char_lcd_write_sequencer_unit.sv
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer_unit
// Character-LCD write sequencer: turns init, command, data, positioned data
// and custom glyph requests into register-select / data-line enable pulses.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each enable pulse
// appears for exactly one cycle with strobe high, and last marks the final
// pulse of a request; the receiver cannot hold pulses off. The front end
// expands a request into 0 to 11 bytes, one byte a cycle while the queue is
// not full, into a four-entry queue; busy stays high until the last byte is
// queued, after which the next request may enter while the back end still
// drains. The back end drives at most one pulse a cycle, one per byte on an
// eight-line bus and two per byte on a four-line bus, so a request gives 0
// to 22 pulses (the most for a four-line custom glyph, none for an unused
// operation code). bus_mode is written through config_write / config_data
// and must only change while no pulses are pending.
// ---------------------------------------------------------------------------
module char_lcd_write_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        config_write,
  input  logic        config_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [7:0]  value,
  input  logic [2:0]  row,
  input  logic [4:0]  column,
  input  logic [2:0]  glyph_slot,
  input  logic [63:0] glyph_rows,
  output logic        strobe,
  output logic        register_select,
  output logic [7:0]  data_lines,
  output logic        last
);

  logic              bus_mode;
  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_empty;
  lcdws_pkg::xfer_t  push_xfer;
  lcdws_pkg::xfer_t  head;

  // Bus width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b0;
    end else if (config_write) begin
      bus_mode <= config_data;
    end
  end

  lcdws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .value      (value),
    .row        (row),
    .column     (column),
    .glyph_slot (glyph_slot),
    .glyph_rows (glyph_rows),
    .bus_mode   (bus_mode),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .push_xfer  (push_xfer)
  );

  lcdws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_xfer (push_xfer),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  lcdws_back u_back (
    .clk             (clk),
    .rst             (rst),
    .bus_mode        (bus_mode),
    .empty           (queue_empty),
    .head            (head),
    .pop             (pop),
    .strobe          (strobe),
    .register_select (register_select),
    .data_lines      (data_lines),
    .last            (last)
  );

endmodule

>>> sv/lcdws_front.sv
// ---------------------------------------------------------------------------
// lcdws_front
// Request front end: captures one request and expands it into its byte
// transfers, pushing one byte a cycle into the queue while it is not full.
// ---------------------------------------------------------------------------
module lcdws_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           operation,
  input  logic [7:0]           value,
  input  logic [2:0]           row,
  input  logic [4:0]           column,
  input  logic [2:0]           glyph_slot,
  input  logic [63:0]          glyph_rows,
  input  logic                 bus_mode,
  input  logic                 queue_full,
  output logic                 busy,
  output logic                 push,
  output lcdws_pkg::xfer_t     push_xfer
);

  logic                          active;
  logic [lcdws_pkg::STEP_W-1:0]  step;
  logic [2:0]                    op_q;
  logic [7:0]                    value_q;
  logic [2:0]                    row_q;
  logic [4:0]                    column_q;
  logic [2:0]                    slot_q;
  logic [63:0]                   rows_q;

  logic                          accept;
  logic                          cursor_ok;
  logic                          in_cursor_ok;
  logic [7:0]                    cursor_byte;
  logic [2:0]                    row_idx;
  logic [lcdws_pkg::STEP_W-1:0]  step_next;

  assign busy   = active;
  assign accept = start && !active;

  // Rows outside 1 to 4 send no cursor command.
  assign cursor_ok    = row_q inside {[3'd1:3'd4]};
  assign in_cursor_ok = row inside {[3'd1:3'd4]};
  assign cursor_byte  = lcdws_pkg::row_base(row_q) + {3'b000, column_q} - 8'd1;
  assign row_idx      = 3'(step - lcdws_pkg::GLYPH_FIRST_ROW);

  // Byte transfer for the current step of the request.
  always_comb begin
    push_xfer = '{rs: lcdws_pkg::RS_CMD, data: 8'h00, last: 1'b1};
    case (op_q)
      lcdws_pkg::OP_INIT: begin
        push_xfer.data = lcdws_pkg::init_byte(step, bus_mode);
        push_xfer.last = (step == lcdws_pkg::INIT_LAST_STEP);
      end
      lcdws_pkg::OP_CMD: begin
        push_xfer.data = value_q;
      end
      lcdws_pkg::OP_DATA: begin
        push_xfer.rs   = lcdws_pkg::RS_DATA;
        push_xfer.data = value_q;
      end
      lcdws_pkg::OP_DATA_AT: begin
        if (step == '0) begin
          push_xfer.data = cursor_byte;
          push_xfer.last = 1'b0;
        end else begin
          push_xfer.rs   = lcdws_pkg::RS_DATA;
          push_xfer.data = value_q;
        end
      end
      lcdws_pkg::OP_GLYPH: begin
        push_xfer.last = 1'b0;
        if (step == '0) begin
          push_xfer.data = {2'b01, slot_q, 3'b000};
        end else if (step <= lcdws_pkg::GLYPH_LAST_ROW) begin
          push_xfer.rs   = lcdws_pkg::RS_DATA;
          push_xfer.data = rows_q[{row_idx, 3'b000} +: 8];
        end else if (step == lcdws_pkg::GLYPH_CURSOR_STEP) begin
          push_xfer.data = cursor_byte;
        end else begin
          push_xfer.rs   = lcdws_pkg::RS_DATA;
          push_xfer.data = {5'b00000, slot_q};
          push_xfer.last = 1'b1;
        end
      end
      default: begin
        push_xfer.last = 1'b1;
      end
    endcase
  end

  assign push = active && !queue_full;

  // A glyph without a valid row skips its cursor step.
  always_comb begin
    if (op_q == lcdws_pkg::OP_GLYPH && step == lcdws_pkg::GLYPH_LAST_ROW && !cursor_ok) begin
      step_next = lcdws_pkg::GLYPH_LAST_STEP;
    end else begin
      step_next = step + 4'd1;
    end
  end

  // Request sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (accept) begin
      active <= operation inside {[lcdws_pkg::OP_INIT:lcdws_pkg::OP_GLYPH]};
      step   <= (operation == lcdws_pkg::OP_DATA_AT && !in_cursor_ok) ? 4'd1 : 4'd0;
    end else if (push) begin
      if (push_xfer.last) begin
        active <= 1'b0;
      end
      step <= step_next;
    end
  end

  // Request payload capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= operation;
      value_q  <= value;
      row_q    <= row;
      column_q <= column;
      slot_q   <= glyph_slot;
      rows_q   <= glyph_rows;
    end
  end

endmodule

>>> sv/lcdws_queue.sv
// ---------------------------------------------------------------------------
// lcdws_queue
// Short byte-transfer queue between the front end and the bus back end.
// The head entry is visible while the queue is not empty.
// ---------------------------------------------------------------------------
module lcdws_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lcdws_pkg::xfer_t  push_xfer,
  input  logic              pop,
  output lcdws_pkg::xfer_t  head,
  output logic              full,
  output logic              empty
);

  lcdws_pkg::xfer_t                mem [lcdws_pkg::QUEUE_DEPTH];
  logic [lcdws_pkg::QPTR_W-1:0]    wr_ptr;
  logic [lcdws_pkg::QPTR_W-1:0]    rd_ptr;
  logic [lcdws_pkg::QCNT_W-1:0]    count;

  assign full  = (count == lcdws_pkg::QCNT_W'(lcdws_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_xfer;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("queue read while empty");

endmodule

>>> sv/lcdws_back.sv
// ---------------------------------------------------------------------------
// lcdws_back
// Bus back end: takes byte transfers from the queue, driving one enable
// pulse a cycle while one waits; a four-line bus gets two nibbles a byte.
// ---------------------------------------------------------------------------
module lcdws_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              bus_mode,
  input  logic              empty,
  input  lcdws_pkg::xfer_t  head,
  output logic              pop,
  output logic              strobe,
  output logic              register_select,
  output logic [7:0]        data_lines,
  output logic              last
);

  logic              pend_low;
  lcdws_pkg::xfer_t  cur;

  // A new byte is taken only when no low nibble is still owed.
  assign pop = !pend_low && !empty;

  // Nibble phase and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_low <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe   <= pend_low || pop;
      pend_low <= pop && !bus_mode;
    end
  end

  // Pulse payload.
  always_ff @(posedge clk) begin
    if (pend_low) begin
      register_select <= cur.rs;
      data_lines      <= {4'h0, cur.data[3:0]};
      last            <= cur.last;
    end else if (pop) begin
      cur             <= head;
      register_select <= head.rs;
      if (bus_mode) begin
        data_lines <= head.data;
        last       <= head.last;
      end else begin
        data_lines <= {4'h0, head.data[7:4]};
        last       <= 1'b0;
      end
    end
  end

  a_high_before_low: assert property (@(posedge clk) disable iff (rst)
    pend_low |-> strobe && !last && data_lines[7:4] == 4'h0)
    else $error("high nibble pulse missing before low nibble");

  a_two_nibbles: assert property (@(posedge clk) disable iff (rst)
    pend_low |=> !pend_low && strobe)
    else $error("low nibble pulse not issued right after high nibble");

  a_pop_strobes: assert property (@(posedge clk) disable iff (rst)
    pop |=> strobe)
    else $error("byte taken from queue without a pulse");

endmodule

>>> verif/char_lcd_write_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer_unit_tb
// Self-checking bench for the character-LCD write sequencer. Requests are
// driven through the start/busy handshake. A local predictor expands each
// accepted request into the enable pulses it should cause on a four-line or
// eight-line bus. Every strobed pulse is checked in order against them.
// Directed requests cover the bus modes, all operations and the cursor edge
// cases. Random traffic with random idle gaps follows.
// ---------------------------------------------------------------------------
module char_lcd_write_sequencer_unit_tb;

  // Operation codes that the block ignores.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Bus mode register values.
  localparam logic MODE_FOUR  = 1'b0;
  localparam logic MODE_EIGHT = 1'b1;

  // DDRAM row bases and the CGRAM address command.
  localparam logic [7:0] ROW1_BASE  = 8'h80;
  localparam logic [7:0] ROW2_BASE  = 8'hC0;
  localparam logic [7:0] ROW3_BASE  = 8'h90;
  localparam logic [7:0] ROW4_BASE  = 8'hD0;
  localparam logic [7:0] CGRAM_BASE = 8'h40;

  // Cycles allowed for a request that produces no pulse to clear the block.
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 340;

  logic        clk;
  logic        rst;
  logic        config_write;
  logic        config_data;
  logic        start;
  logic        busy;
  logic [2:0]  operation;
  logic [7:0]  value;
  logic [2:0]  row;
  logic [4:0]  column;
  logic [2:0]  glyph_slot;
  logic [63:0] glyph_rows;
  logic        strobe;
  logic        register_select;
  logic [7:0]  data_lines;
  logic        last;

  // Predictor state: bus mode shadow and the pulses still to come.
  logic               eight_lines;
  lcdws_pkg::xfer_t   pending_pulses[$];
  int                 fault_count;
  int                 quiet_left;

  char_lcd_write_sequencer_unit uut (
    .clk             (clk),
    .rst             (rst),
    .config_write    (config_write),
    .config_data     (config_data),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .value           (value),
    .row             (row),
    .column          (column),
    .glyph_slot      (glyph_slot),
    .glyph_rows      (glyph_rows),
    .strobe          (strobe),
    .register_select (register_select),
    .data_lines      (data_lines),
    .last            (last)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Queue the pulses of one byte for the current bus width.
  function automatic void push_byte(input logic rs, input logic [7:0] b);
    lcdws_pkg::xfer_t p;
    p.rs   = rs;
    p.last = 1'b0;
    if (eight_lines) begin
      p.data = b;
      pending_pulses.push_back(p);
    end else begin
      p.data = {4'h0, b[7:4]};
      pending_pulses.push_back(p);
      p.data = {4'h0, b[3:0]};
      pending_pulses.push_back(p);
    end
  endfunction

  // Queue the cursor command; rows outside 1 to 4 send nothing.
  function automatic void push_cursor(input logic [2:0] r, input logic [4:0] c);
    logic [7:0] base;
    case (r)
      3'd1: base = ROW1_BASE;
      3'd2: base = ROW2_BASE;
      3'd3: base = ROW3_BASE;
      3'd4: base = ROW4_BASE;
      default: return;
    endcase
    push_byte(lcdws_pkg::RS_CMD, base + {3'b000, c} - 8'd1);
  endfunction

  // Expand one accepted request into the enable pulses it should cause.
  function automatic void expand_request(input logic [2:0] op, input logic [7:0] v,
                                         input logic [2:0] r, input logic [4:0] c,
                                         input logic [2:0] slot, input logic [63:0] rows);
    int before_count;
    before_count = pending_pulses.size();
    case (op)
      lcdws_pkg::OP_INIT: begin
        push_byte(lcdws_pkg::RS_CMD, 8'h38);
        push_byte(lcdws_pkg::RS_CMD, 8'h38);
        push_byte(lcdws_pkg::RS_CMD, 8'h38);
        push_byte(lcdws_pkg::RS_CMD, 8'h01);
        push_byte(lcdws_pkg::RS_CMD, 8'h02);
        push_byte(lcdws_pkg::RS_CMD, 8'h06);
        push_byte(lcdws_pkg::RS_CMD, 8'h0C);
        push_byte(lcdws_pkg::RS_CMD, eight_lines ? 8'h38 : 8'h28);
        push_byte(lcdws_pkg::RS_CMD, 8'h80);
      end
      lcdws_pkg::OP_CMD: push_byte(lcdws_pkg::RS_CMD, v);
      lcdws_pkg::OP_DATA: push_byte(lcdws_pkg::RS_DATA, v);
      lcdws_pkg::OP_DATA_AT: begin
        push_cursor(r, c);
        push_byte(lcdws_pkg::RS_DATA, v);
      end
      lcdws_pkg::OP_GLYPH: begin
        push_byte(lcdws_pkg::RS_CMD, CGRAM_BASE | {2'b00, slot, 3'b000});
        for (int i = 0; i < 8; i++) push_byte(lcdws_pkg::RS_DATA, rows[8*i +: 8]);
        push_cursor(r, c);
        push_byte(lcdws_pkg::RS_DATA, {5'b00000, slot});
      end
      default: ;
    endcase
    // The final pulse of the request carries last.
    if (pending_pulses.size() > before_count)
      pending_pulses[pending_pulses.size() - 1].last = 1'b1;
  endfunction

  // Check each strobed pulse against the oldest expected one.
  always @(posedge clk) begin
    lcdws_pkg::xfer_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_pulses.size() == 0) begin
        $error("unexpected pulse: register_select %0d, data_lines %h, last %0d",
               register_select, data_lines, last);
        fault_count++;
      end else begin
        want = pending_pulses.pop_front();
        if (register_select !== want.rs) begin
          $error("register_select: expected %0d, got %0d", want.rs, register_select);
          fault_count++;
        end
        if (data_lines !== want.data) begin
          $error("data_lines: expected %h, got %h", want.data, data_lines);
          fault_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fault_count++;
        end
      end
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [2:0] op, input logic [7:0] v,
                              input logic [2:0] r, input logic [4:0] c,
                              input logic [2:0] slot, input logic [63:0] rows);
    @(negedge clk);
    start      <= 1'b1;
    operation  <= op;
    value      <= v;
    row        <= r;
    column     <= c;
    glyph_slot <= slot;
    glyph_rows <= rows;
    do @(posedge clk); while (busy !== 1'b0);
    expand_request(op, v, r, c, slot, rows);
  endtask

  // Random idle gap after a request: mostly none or short, a few long, and
  // now and then a run of back-to-back requests.
  task automatic rest_sender();
    int n;
    int pick;
    n = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5) quiet_left = $urandom_range(10, 30);
      else if (pick < 55) n = 0;
      else if (pick < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
    end
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every expected pulse has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the bus mode register once the block is idle.
  task automatic set_bus_mode(input logic mode);
    wait_for_drain();
    @(negedge clk);
    config_write <= 1'b1;
    config_data  <= mode;
    eight_lines  = mode;
    @(negedge clk);
    config_write <= 1'b0;
  endtask

  // Draw one random request; most are well formed, some use odd rows,
  // columns or unused operation codes.
  task automatic send_random_request(output logic useful);
    logic [2:0]  op;
    logic [2:0]  r;
    logic [4:0]  c;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) op = lcdws_pkg::OP_INIT;
    else if (pick < 24) op = lcdws_pkg::OP_CMD;
    else if (pick < 44) op = lcdws_pkg::OP_DATA;
    else if (pick < 72) op = lcdws_pkg::OP_DATA_AT;
    else if (pick < 94) op = lcdws_pkg::OP_GLYPH;
    else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    r = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    c = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(0, 31));
    send_request(op, 8'($urandom_range(0, 255)), r, c, 3'($urandom_range(0, 7)),
                 {$urandom(), $urandom()});
    useful = (op <= lcdws_pkg::OP_GLYPH);
  endtask

  // Directed requests on the four-line bus, including the cursor corners.
  task automatic test_four_line_directed();
    set_bus_mode(MODE_FOUR);
    send_request(lcdws_pkg::OP_INIT, 8'h00, 3'd0, 5'd0, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_CMD, 8'h00, 3'd0, 5'd0, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_CMD, 8'hFF, 3'd7, 5'd31, 3'd7, '1);
    send_request(lcdws_pkg::OP_DATA, 8'h5A, 3'd1, 5'd1, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'h41, 3'd1, 5'd1, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'hFF, 3'd2, 5'd16, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'h00, 3'd3, 5'd8, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'h7E, 3'd4, 5'd16, 3'd0, 64'h0);
    // Rows outside 1 to 4 skip the cursor command.
    send_request(lcdws_pkg::OP_DATA_AT, 8'h30, 3'd0, 5'd1, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'h31, 3'd5, 5'd2, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'h32, 3'd7, 5'd3, 3'd0, 64'h0);
    // Columns outside 1 to 16 are not checked; the address is kept to eight bits.
    send_request(lcdws_pkg::OP_DATA_AT, 8'h33, 3'd1, 5'd0, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'h34, 3'd4, 5'd31, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_GLYPH, 8'h00, 3'd1, 5'd1, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_GLYPH, 8'hFF, 3'd4, 5'd16, 3'd7, '1);
    send_request(lcdws_pkg::OP_GLYPH, 8'h00, 3'd6, 5'd9, 3'd3, 64'h0123_4567_89AB_CDEF);
    // Unused operation codes produce nothing.
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      send_request(3'(op), 8'hFF, 3'd1, 5'd1, 3'd7, '1);
  endtask

  // Directed requests on the eight-line bus.
  task automatic test_eight_line_directed();
    set_bus_mode(MODE_EIGHT);
    send_request(lcdws_pkg::OP_INIT, 8'h00, 3'd0, 5'd0, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_CMD, 8'hA5, 3'd0, 5'd0, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA, 8'h00, 3'd0, 5'd0, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_DATA_AT, 8'hC3, 3'd2, 5'd3, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_GLYPH, 8'h00, 3'd3, 5'd2, 3'd5, 64'hFEDC_BA98_7654_3210);
    send_request(OP_UNUSED_HI, 8'h00, 3'd0, 5'd0, 3'd0, 64'h0);
  endtask

  // The sender holds off until every pulse is out, then resumes.
  task automatic test_pause_until_drained();
    send_request(lcdws_pkg::OP_GLYPH, 8'h00, 3'd2, 5'd4, 3'd1, {$urandom(), $urandom()});
    send_request(lcdws_pkg::OP_DATA_AT, 8'h55, 3'd3, 5'd12, 3'd0, 64'h0);
    wait_for_drain();
    send_request(lcdws_pkg::OP_INIT, 8'h00, 3'd0, 5'd0, 3'd0, 64'h0);
    send_request(lcdws_pkg::OP_GLYPH, 8'h00, 3'd4, 5'd7, 3'd6, {$urandom(), $urandom()});
  endtask

  // Random traffic in phases, each with its own bus mode.
  task automatic test_random_traffic();
    int   sent;
    logic useful;
    for (int phase = 0; phase < 4; phase++) begin
      set_bus_mode(phase[0] ? MODE_EIGHT : MODE_FOUR);
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        send_random_request(useful);
        if (useful) sent++;
        if ($urandom_range(0, 99) < 2) wait_for_drain();
        else rest_sender();
      end
    end
  endtask

  // Run control.
  initial begin
    rst          <= 1'b1;
    config_write <= 1'b0;
    config_data  <= 1'b0;
    start        <= 1'b0;
    operation    <= lcdws_pkg::OP_INIT;
    value        <= 8'h00;
    row          <= 3'd0;
    column       <= 5'd0;
    glyph_slot   <= 3'd0;
    glyph_rows   <= 64'h0;
    eight_lines  = MODE_FOUR;
    fault_count  = 0;
    quiet_left   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_four_line_directed();
    test_eight_line_directed();
    test_pause_until_drained();
    test_random_traffic();
    wait_for_drain();

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
